>>> rtl/gn3d_pkg.sv
// Package for the 3D gradient noise block: widths, permutation table, gradient rule.
// Depends on nothing; used by all files in rtl.
package gn3d_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int LATTICE_BITS_DEF = 8;
	localparam int COORD_W          = 24;

	localparam logic [7:0] PERM_TBL [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
		8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
		8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
		8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
		8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
		8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
		8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
		8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
		8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
		8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
		8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
		8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
		8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
		8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
		8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
		8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,
		8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
		8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,
		8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,
		8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,
		8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
	};

	localparam logic [3:0] H_SWAP_A = 4'd12;
	localparam logic [3:0] H_SWAP_B = 4'd14;

	function automatic logic [7:0] perm(input logic [7:0] i);
		perm = PERM_TBL[i];
	endfunction

	// Gradient dot product on offsets of width W (signed, W bits), result W+1 bits.
	function automatic logic signed [31:0] grad(input logic [3:0] h,
		input logic signed [31:0] x, input logic signed [31:0] y,
		input logic signed [31:0] z);
		logic signed [31:0] u;
		logic signed [31:0] v;
		u = (h < 4'd8) ? x : y;
		v = (h < 4'd4) ? y : ((h == H_SWAP_A || h == H_SWAP_B) ? x : z);
		grad = (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

endpackage

>>> rtl/gn3d_fade.sv
// Pipelined quintic fade 6t^5-15t^4+10t^3, three register stages.
// Depends on gn3d_pkg for the default of FRAC_BITS.
module gn3d_fade #(
	parameter int FRAC_BITS = gn3d_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] t,
	output logic [FRAC_BITS:0]   fade
);
	import gn3d_pkg::*;

	localparam int W = FRAC_BITS + 5;
	localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;

	logic signed [W-1:0] t_s1, t2_s1, a_s1;
	logic signed [W-1:0] t3_s2, b_s2;
	logic signed [W-1:0] f_s3;
	logic signed [2*W-1:0] p_t2, p_t3, p_b, p_f;
	logic signed [W-1:0] t_in;

	assign t_in = W'({1'b0, t});
	assign p_t2 = t_in * t_in;
	assign p_t3 = t2_s1 * t_s1;
	assign p_b  = t_s1 * a_s1;
	assign p_f  = t3_s2 * b_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= t_in;
			t2_s1 <= W'(p_t2 >>> FRAC_BITS);
			a_s1  <= W'(t_in * 6) - W'(ONE * 15);
			t3_s2 <= W'(p_t3 >>> FRAC_BITS);
			b_s2  <= W'(p_b >>> FRAC_BITS) + W'(ONE * 10);
			f_s3  <= W'(p_f >>> FRAC_BITS);
		end
	end

	assign fade = f_s3[FRAC_BITS:0];
endmodule

>>> rtl/gradient_noise_3d_top.sv
// Top level of the 3D improved gradient noise block.
// Depends on gn3d_pkg and gn3d_fade.
//
// Usage: one point (coord_x, coord_y, coord_z) enters per input beat
// (in_valid/in_stall); one noise_value leaves per output beat
// (out_valid/out_stall). Coordinates are unsigned with 8 lattice bits over
// FRAC_BITS fraction bits; higher bits are ignored.
// Throughput: one beat per cycle unless out_stall holds a full output. An
// accepted beat reaches out_valid through seven register stages (two
// hash lookups, gradient codes, gradients, three lerp levels, the last one
// being the output register); the fade pipeline runs beside the hashes.
// A global stall freezes every stage whenever the output register is full
// and stalled; in_stall then follows, so nothing is lost or repeated.
// Reset clears only the valid bits; the data path has no reset.
// The result saturates to signed Q2.FRAC_BITS.
module gradient_noise_3d_top #(
	parameter int FRAC_BITS = gn3d_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gn3d_pkg::COORD_W-1:0]  coord_x,
	input  logic [gn3d_pkg::COORD_W-1:0]  coord_y,
	input  logic [gn3d_pkg::COORD_W-1:0]  coord_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [FRAC_BITS+1:0]   noise_value
);
	import gn3d_pkg::*;

	localparam int NST = 7;
	localparam int GW  = FRAC_BITS + 4;   // gradient and lerp width
	localparam int PW  = 2 * GW;
	localparam logic signed [GW-1:0] ONE = GW'(1) <<< FRAC_BITS;
	localparam logic signed [GW-1:0] HI  = GW'(2) * ONE - GW'(1);
	localparam logic signed [GW-1:0] LO  = -(GW'(2) * ONE);

	logic [NST-1:0] vld_q;
	logic           adv;

	// advance whenever the last stage can move on
	assign adv       = !vld_q[NST-1] || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// Stage 1: lattice cell and first-level hashes
	logic [FRAC_BITS-1:0] fx_s1, fy_s1, fz_s1;
	logic [7:0] y_s1, z_s1, pa_s1, pb_s1;
	logic [7:0] cx, cy, cz;
	assign cx = coord_x[FRAC_BITS +: 8];
	assign cy = coord_y[FRAC_BITS +: 8];
	assign cz = coord_z[FRAC_BITS +: 8];

	// Stage 2: second-level hashes
	logic [FRAC_BITS-1:0] fx_s2, fy_s2, fz_s2;
	logic [7:0] z_s2, aa_s2, ab_s2, ba_s2, bb_s2;
	logic [7:0] a_c, b_c;
	assign a_c = pa_s1 + y_s1;
	assign b_c = pb_s1 + y_s1;

	// Stage 3: corner hashes reduced to gradient codes
	logic [FRAC_BITS-1:0] fx_s3, fy_s3, fz_s3;
	logic [3:0] h_s3 [8];
	logic [7:0] aa_c, ab_c, ba_c, bb_c;
	logic [7:0] hc [8];
	assign aa_c = aa_s2 + z_s2;
	assign ab_c = ab_s2 + z_s2;
	assign ba_c = ba_s2 + z_s2;
	assign bb_c = bb_s2 + z_s2;
	assign hc[0] = perm(aa_c);
	assign hc[1] = perm(ba_c);
	assign hc[2] = perm(ab_c);
	assign hc[3] = perm(bb_c);
	assign hc[4] = perm(aa_c + 8'd1);
	assign hc[5] = perm(ba_c + 8'd1);
	assign hc[6] = perm(ab_c + 8'd1);
	assign hc[7] = perm(bb_c + 8'd1);

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s1 <= coord_x[FRAC_BITS-1:0];
			fy_s1 <= coord_y[FRAC_BITS-1:0];
			fz_s1 <= coord_z[FRAC_BITS-1:0];
			y_s1  <= cy;
			z_s1  <= cz;
			pa_s1 <= perm(cx);
			pb_s1 <= perm(cx + 8'd1);
			fx_s2 <= fx_s1; fy_s2 <= fy_s1; fz_s2 <= fz_s1;
			z_s2  <= z_s1;
			aa_s2 <= perm(a_c);
			ab_s2 <= perm(a_c + 8'd1);
			ba_s2 <= perm(b_c);
			bb_s2 <= perm(b_c + 8'd1);
			fx_s3 <= fx_s2; fy_s3 <= fy_s2; fz_s3 <= fz_s2;
			for (int i = 0; i < 8; i++) h_s3[i] <= hc[i][3:0];
		end
	end

	// Fades: entering with the input beat, ready with stage 3
	logic [FRAC_BITS:0] fu, fv, fw;
	gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (.clk, .en(adv),
		.t(coord_x[FRAC_BITS-1:0]), .fade(fu));
	gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (.clk, .en(adv),
		.t(coord_y[FRAC_BITS-1:0]), .fade(fv));
	gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (.clk, .en(adv),
		.t(coord_z[FRAC_BITS-1:0]), .fade(fw));

	// Stage 4: corner gradients, feeding the first lerp level
	logic signed [31:0] ox0, oy0, oz0, ox1, oy1, oz1;
	logic signed [31:0] g [8];
	assign ox0 = 32'({1'b0, fx_s3});
	assign oy0 = 32'({1'b0, fy_s3});
	assign oz0 = 32'({1'b0, fz_s3});
	assign ox1 = ox0 - 32'(ONE);
	assign oy1 = oy0 - 32'(ONE);
	assign oz1 = oz0 - 32'(ONE);
	always_comb begin
		g[0] = grad(h_s3[0], ox0, oy0, oz0);
		g[1] = grad(h_s3[1], ox1, oy0, oz0);
		g[2] = grad(h_s3[2], ox0, oy1, oz0);
		g[3] = grad(h_s3[3], ox1, oy1, oz0);
		g[4] = grad(h_s3[4], ox0, oy0, oz1);
		g[5] = grad(h_s3[5], ox1, oy0, oz1);
		g[6] = grad(h_s3[6], ox0, oy1, oz1);
		g[7] = grad(h_s3[7], ox1, oy1, oz1);
	end

	logic signed [GW-1:0] g_s4 [8];
	logic signed [GW-1:0] fu_s4;
	logic signed [GW-1:0] l_s5 [4];
	logic signed [GW-1:0] m_s6 [2];
	logic signed [GW-1:0] fv_s5, fw_s5, fw_s6;
	logic signed [GW-1:0] r_s7;
	logic signed [PW-1:0] p1 [4];
	logic signed [PW-1:0] p2 [2];
	logic signed [PW-1:0] p3;
	logic signed [GW-1:0] fv_s4, fw_s4;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			p1[i] = PW'(fu_s4) * PW'(g_s4[2*i+1] - g_s4[2*i]);
		end
		for (int i = 0; i < 2; i++) begin
			p2[i] = PW'(fv_s5) * PW'(l_s5[2*i+1] - l_s5[2*i]);
		end
		p3 = PW'(fw_s6) * PW'(m_s6[1] - m_s6[0]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 8; i++) g_s4[i] <= GW'(g[i]);
			fu_s4 <= GW'({1'b0, fu});
			fv_s4 <= GW'({1'b0, fv});
			fw_s4 <= GW'({1'b0, fw});
			for (int i = 0; i < 4; i++) l_s5[i] <= g_s4[2*i] + GW'(p1[i] >>> FRAC_BITS);
			fv_s5 <= fv_s4; fw_s5 <= fw_s4;
			for (int i = 0; i < 2; i++) m_s6[i] <= l_s5[2*i] + GW'(p2[i] >>> FRAC_BITS);
			fw_s6 <= fw_s5;
			r_s7  <= m_s6[0] + GW'(p3 >>> FRAC_BITS);
		end
	end

	// saturate to Q2.FRAC_BITS
	always_comb begin
		if (r_s7 > HI)      noise_value = HI[FRAC_BITS+1:0];
		else if (r_s7 < LO) noise_value = LO[FRAC_BITS+1:0];
		else                noise_value = r_s7[FRAC_BITS+1:0];
	end

	// hold output while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(noise_value))
		else $error("output changed under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !vld_q[NST-2] |=> !out_valid)
		else $error("output valid without item in flight");
endmodule
